@@ hw/rtl/image_rotate_nearest_assert.svh @@
// Assertion macros for the nearest-neighbor rotation block.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef IMAGE_ROTATE_NEAREST_ASSERT_SVH
`define IMAGE_ROTATE_NEAREST_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define IRN_CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define IRN_CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold on the cycle after reset is seen.
`define IRN_CHK_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/irn_pkg.sv @@
`default_nettype none

package irn_pkg;

  // Fixed field widths
  localparam int COORD_W = 10;
  localparam int DIM_W   = 10;
  localparam int TRIG_W  = 16;
  localparam int COLOR_W = 8;
  localparam int SIZE_W  = 11;
  localparam int DELTA_W = 12;                 // doubled offset 2x - W
  localparam int PROD_W  = TRIG_W + DELTA_W;   // trig times doubled offset

  // Command codes
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SRC_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_SRC_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_COS_VALUE  = 2'd2;
  localparam cfg_idx_t CFG_SIN_VALUE  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [DIM_W-1:0]         SRC_WIDTH_RST  = 10'd512;
  localparam logic [DIM_W-1:0]         SRC_HEIGHT_RST = 10'd512;
  localparam logic signed [TRIG_W-1:0] COS_VALUE_RST  = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] SIN_VALUE_RST  = 16'sd0;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 8'd255;
  localparam logic [SIZE_W-1:0]  SIZE_SAT    = 11'd2047;

  // One frame-store pixel
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pix_t;

endpackage

`default_nettype wire

@@ hw/rtl/irn_ram.sv @@
`default_nettype none

module irn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read, read data holds while en is low
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/image_rotate_nearest.sv @@
// A read shows its result from the stage 8 result register; writes give no result.
// Throughput: one command per cycle; the pipeline holds as a whole only while a result
// is waiting in the output register and the output side stalls.
// Writes and reads share the single frame-store port at the same stage, so they keep order.
// Reset (rst, synchronous, active high): configuration returns to 512 x 512, cos 1.0,
// sin 0, and all pipeline valids clear; frame-store contents are left as they are.
`default_nettype none

module image_rotate_nearest #(
  parameter int MAX_WIDTH          = 512,
  parameter int MAX_HEIGHT         = 512,
  parameter int TRIG_FRACTION_BITS = 14
) (
  input  logic                     clk,
  input  logic                     rst,
  // command channel
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  irn_pkg::cmd_t            command,
  input  logic [9:0]               coord_x,
  input  logic [9:0]               coord_y,
  input  logic [7:0]               in_blue,
  input  logic [7:0]               in_green,
  input  logic [7:0]               in_red,
  // result channel
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [7:0]               out_blue,
  output logic [7:0]               out_green,
  output logic [7:0]               out_red,
  output logic                     inside_res,
  output logic [10:0]              out_width,
  output logic [10:0]              out_height,
  // configuration channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  irn_pkg::cfg_idx_t        cfg_index,
  input  logic [15:0]              cfg_data
);

  import irn_pkg::*;

  localparam int F     = TRIG_FRACTION_BITS;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DW    = (WW > HW) ? WW : HW;
  localparam int MPW   = DW + TRIG_W;
  localparam int SZW   = MPW + 1;
  localparam int SUMW  = (((PROD_W + 1) > (DW + F)) ? (PROD_W + 1) : (DW + F)) + 2;
  localparam int MW    = SUMW - F - 1;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]         src_width;
  logic [DIM_W-1:0]         src_height;
  logic signed [TRIG_W-1:0] cos_value;
  logic signed [TRIG_W-1:0] sin_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SRC_WIDTH_RST;
      src_height <= SRC_HEIGHT_RST;
      cos_value  <= COS_VALUE_RST;
      sin_value  <= SIN_VALUE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= cfg_data[DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height <= cfg_data[DIM_W-1:0];
        CFG_COS_VALUE:  cos_value  <= $signed(cfg_data);
        CFG_SIN_VALUE:  sin_value  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Terms that follow only from configuration (registered from the configuration registers)
  // ---------------------------------------------------------------------------
  logic [DW-1:0]            w_lim, h_lim;
  logic [TRIG_W-1:0]        cos_mag, sin_mag;
  logic [DW-1:0]            dim_w, dim_h;
  logic [MPW-1:0]           prod_wc, prod_hs, prod_ws, prod_hc;
  logic signed [SUMW-1:0]   off_x, off_y;

  always_comb begin
    w_lim   = (32'(src_width) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(src_width);
    h_lim   = (32'(src_height) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : DW'(src_height);
    cos_mag = cos_value[TRIG_W-1] ? TRIG_W'(-cos_value) : TRIG_W'(cos_value);
    sin_mag = sin_value[TRIG_W-1] ? TRIG_W'(-sin_value) : TRIG_W'(sin_value);
  end

  always_ff @(posedge clk) begin
    dim_w   <= w_lim;
    dim_h   <= h_lim;
    prod_wc <= MPW'(w_lim) * MPW'(cos_mag);
    prod_hs <= MPW'(h_lim) * MPW'(sin_mag);
    prod_ws <= MPW'(w_lim) * MPW'(sin_mag);
    prod_hc <= MPW'(h_lim) * MPW'(cos_mag);
    off_x   <= $signed(SUMW'(w_lim) << F);
    off_y   <= $signed(SUMW'(h_lim) << F);
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: everything advances unless a result waits and is stalled
  // ---------------------------------------------------------------------------
  logic adv;
  logic cmd_xfer;
  logic v1, v2, v3, v4, v5, v6, v7, v8;
  cmd_t cmd1, cmd2, cmd3, cmd4, cmd5, cmd6, cmd7;

  assign adv       = !(v8 && res_stall);
  assign cmd_stall = rst || !adv;
  assign cmd_xfer  = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (adv) begin
      v1 <= cmd_xfer;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7 && (cmd7 == CMD_READ);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the command
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] x1, x2, x3, x4, x5, x6;
  logic [COORD_W-1:0] y1, y2, y3, y4, y5, y6;
  pix_t               pix1, pix2, pix3, pix4, pix5, pix6, pix7;

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1 <= command;
      x1   <= coord_x;
      y1   <= coord_y;
      pix1 <= '{red: in_red, green: in_green, blue: in_blue};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: output size, truncated and saturated
  // ---------------------------------------------------------------------------
  logic [SZW-1:0]    sum_w, sum_h, shf_w, shf_h;
  logic [SIZE_W-1:0] ow2, oh2, ow3, oh3, ow4, oh4, ow5, oh5, ow6, oh6, ow7, oh7, ow8, oh8;

  always_comb begin
    sum_w = SZW'(prod_wc) + SZW'(prod_hs);
    sum_h = SZW'(prod_ws) + SZW'(prod_hc);
    shf_w = sum_w >> F;
    shf_h = sum_h >> F;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ow2  <= (shf_w > SZW'(SIZE_SAT)) ? SIZE_SAT : SIZE_W'(shf_w);
      oh2  <= (shf_h > SZW'(SIZE_SAT)) ? SIZE_SAT : SIZE_W'(shf_h);
      cmd2 <= cmd1;
      x2   <= x1;
      y2   <= y1;
      pix2 <= pix1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: doubled offsets from the output center and output range check
  // ---------------------------------------------------------------------------
  logic signed [DELTA_W-1:0] dx3, dy3;
  logic                      in_out3, in_out4, in_out5, in_out6;

  always_ff @(posedge clk) begin
    if (adv) begin
      dx3     <= $signed({1'b0, x2, 1'b0}) - $signed({1'b0, ow2});
      dy3     <= $signed({1'b0, y2, 1'b0}) - $signed({1'b0, oh2});
      in_out3 <= ({1'b0, x2} < ow2) && ({1'b0, y2} < oh2);
      ow3     <= ow2;
      oh3     <= oh2;
      cmd3    <= cmd2;
      x3      <= x2;
      y3      <= y2;
      pix3    <= pix2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: the four rotation products
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] p_cx4, p_sy4, p_sx4, p_cy4;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_cx4   <= cos_value * dx3;
      p_sy4   <= sin_value * dy3;
      p_sx4   <= sin_value * dx3;
      p_cy4   <= cos_value * dy3;
      in_out4 <= in_out3;
      ow4     <= ow3;
      oh4     <= oh3;
      cmd4    <= cmd3;
      x4      <= x3;
      y4      <= y3;
      pix4    <= pix3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: source position scaled by 2^(F+1)
  // ---------------------------------------------------------------------------
  logic signed [SUMW-1:0] pos_x5, pos_y5;

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x5  <= SUMW'(p_cx4) + SUMW'(p_sy4) + off_x;
      pos_y5  <= SUMW'(p_cy4) - SUMW'(p_sx4) + off_y;
      in_out5 <= in_out4;
      ow5     <= ow4;
      oh5     <= oh4;
      cmd5    <= cmd4;
      x5      <= x4;
      y5      <= y4;
      pix5    <= pix4;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: round the magnitude half away from zero, keep the sign
  // ---------------------------------------------------------------------------
  localparam logic [SUMW-1:0] HALF     = SUMW'(1) << F;
  localparam logic [SUMW-1:0] HALF_NEG = HALF + SUMW'(1);

  logic [SUMW-1:0] rnd_x, rnd_y;
  logic [MW-1:0]   mx6, my6;
  logic            neg_x6, neg_y6;

  always_comb begin
    // |v| + half in one add: for negative v, ~v + 1 + half
    rnd_x = pos_x5[SUMW-1] ? (~pos_x5 + HALF_NEG) : (pos_x5 + HALF);
    rnd_y = pos_y5[SUMW-1] ? (~pos_y5 + HALF_NEG) : (pos_y5 + HALF);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx6     <= MW'(rnd_x >> (F + 1));
      my6     <= MW'(rnd_y >> (F + 1));
      neg_x6  <= pos_x5[SUMW-1];
      neg_y6  <= pos_y5[SUMW-1];
      in_out6 <= in_out5;
      ow6     <= ow5;
      oh6     <= oh5;
      cmd6    <= cmd5;
      x6      <= x5;
      y6      <= y5;
      pix6    <= pix5;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: source bounds check and frame-store address
  // ---------------------------------------------------------------------------
  logic          ok_x, ok_y, wr_ok;
  logic [XW-1:0] col_sel;
  logic [YW-1:0] row_sel;
  logic [AW-1:0] addr7;
  logic          we7, inside7, inside8;

  always_comb begin
    // a negative position is inside only when it rounds to zero
    ok_x    = (!neg_x6 || (mx6 == '0)) && (mx6 < MW'(dim_w));
    ok_y    = (!neg_y6 || (my6 == '0)) && (my6 < MW'(dim_h));
    wr_ok   = (32'(x6) < MAX_WIDTH) && (32'(y6) < MAX_HEIGHT);
    col_sel = (cmd6 == CMD_READ) ? XW'(mx6) : XW'(x6);
    row_sel = (cmd6 == CMD_READ) ? YW'(my6) : YW'(y6);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      addr7   <= AW'(row_sel) * AW'(MAX_WIDTH) + AW'(col_sel);
      we7     <= v6 && (cmd6 == CMD_WRITE) && wr_ok;
      inside7 <= in_out6 && ok_x && ok_y;
      ow7     <= ow6;
      oh7     <= oh6;
      cmd7    <= cmd6;
      pix7    <= pix6;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: frame-store access and result register
  // ---------------------------------------------------------------------------
  pix_t rd_pix;

  irn_ram #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .en    (adv),
    .we    (we7 && v7),
    .addr  (addr7),
    .wdata (pix7),
    .rdata (rd_pix)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      inside8 <= inside7;
      ow8     <= ow7;
      oh8     <= oh7;
    end
  end

  // Substitute white background outside the source
  assign res_valid  = v8;
  assign inside_res = inside8;
  assign out_blue   = inside8 ? rd_pix.blue  : COLOR_WHITE;
  assign out_green  = inside8 ? rd_pix.green : COLOR_WHITE;
  assign out_red    = inside8 ? rd_pix.red   : COLOR_WHITE;
  assign out_width  = ow8;
  assign out_height = oh8;

endmodule

`default_nettype wire

@@ hw/rtl/irn_checker.sv @@
`default_nettype none

`include "image_rotate_nearest_assert.svh"

module irn_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_stall,
  input  irn_pkg::cmd_t     command,
  input  logic              res_valid,
  input  logic              res_stall,
  input  logic [7:0]        out_blue,
  input  logic [7:0]        out_green,
  input  logic [7:0]        out_red,
  input  logic              inside_res,
  input  logic [10:0]       out_width,
  input  logic [10:0]       out_height
);

  import irn_pkg::*;

  logic       rd_xfer, res_xfer;
  logic [3:0] pending;

  assign rd_xfer  = cmd_valid && !cmd_stall && (command == CMD_READ);
  assign res_xfer = res_valid && !res_stall;

  // Track reads taken in but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(rd_xfer) - 4'(res_xfer);
    end
  end

  `IRN_CHK_NEXT(a_res_hold, res_valid && res_stall, res_valid, "result dropped while stalled")
  `IRN_CHK_NEXT(a_res_stable, res_valid && res_stall,
    $stable(out_blue) && $stable(out_green) && $stable(out_red) &&
    $stable(inside_res) && $stable(out_width) && $stable(out_height),
    "result changed while stalled")
  `IRN_CHK_NOW(a_white_bg, res_valid && !inside_res,
    out_blue == COLOR_WHITE && out_green == COLOR_WHITE && out_red == COLOR_WHITE,
    "background pixel is not white")
  `IRN_CHK_NOW(a_no_orphan, res_valid, pending != 4'd0, "result without a pending read")
  `IRN_CHK_RESET(a_reset_idle, !res_valid, "result valid right after reset")

endmodule

bind image_rotate_nearest irn_checker u_irn_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd_valid),
  .cmd_stall  (cmd_stall),
  .command    (command),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .out_blue   (out_blue),
  .out_green  (out_green),
  .out_red    (out_red),
  .inside_res (inside_res),
  .out_width  (out_width),
  .out_height (out_height)
);

`default_nettype wire

@@ tb/sv/tb_image_rotate_nearest.sv @@
`timescale 1ns / 100ps

module tb_image_rotate_nearest;
  import irn_pkg::*;

  localparam int MAX_W        = 512;
  localparam int MAX_H        = 512;
  localparam int FRAC         = 14;
  localparam int LATENCY      = 7;
  localparam int RANDOM_ITEMS = 800;

  // One pixel command as the driver presents it
  typedef struct packed {
    cmd_t       op;
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [4:0] gap;
    logic       hold;
  } pixel_cmd_t;

  // One rotated pixel as the block returns it
  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        in_src;
    logic [10:0] width;
    logic [10:0] height;
  } rotated_pix_t;

  // Where an output pixel lands in the source, plus the output size
  typedef struct packed {
    logic        hit;
    logic [17:0] addr;
    logic [10:0] ow;
    logic [10:0] oh;
  } sample_t;

  logic        clk;
  logic        rst        = 1'b1;
  logic        cmd_valid  = 1'b0;
  logic        cmd_stall;
  cmd_t        command    = CMD_WRITE;
  logic [9:0]  coord_x    = '0;
  logic [9:0]  coord_y    = '0;
  logic [7:0]  in_blue    = '0;
  logic [7:0]  in_green   = '0;
  logic [7:0]  in_red     = '0;
  logic        res_valid;
  logic        res_stall  = 1'b0;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic        inside_res;
  logic [10:0] out_width;
  logic [10:0] out_height;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index  = CFG_SRC_WIDTH;
  logic [15:0] cfg_data   = '0;

  // Configuration as last written into the block
  logic [9:0]         src_w_reg = SRC_WIDTH_RST;
  logic [9:0]         src_h_reg = SRC_HEIGHT_RST;
  logic signed [15:0] cos_reg   = COS_VALUE_RST;
  logic signed [15:0] sin_reg   = SIN_VALUE_RST;

  // Frame store contents as the block should hold them
  logic [23:0] frame_model [0:MAX_W*MAX_H-1];
  // Entries that some queued write has defined
  bit          pix_written [0:MAX_W*MAX_H-1];

  pixel_cmd_t   pending_cmds [$];
  rotated_pix_t expected_pix [$];

  pixel_cmd_t   cur_cmd;
  sample_t      fetch;
  rotated_pix_t want;
  int           idle_count = 0;
  int           stall_left = 0;
  int           err_count  = 0;
  int           item_total = 0;
  bit           no_idle    = 1'b0;

  image_rotate_nearest #(
    .MAX_WIDTH         (MAX_W),
    .MAX_HEIGHT        (MAX_H),
    .TRIG_FRACTION_BITS(FRAC)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .in_blue   (in_blue),
    .in_green  (in_green),
    .in_red    (in_red),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .inside_res(inside_res),
    .out_width (out_width),
    .out_height(out_height),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (err_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic int draw_idle();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // Divide by 2^(FRAC+1), rounding half away from zero on the magnitude
  function automatic longint nearest_index(longint v);
    longint m;
    m = ((v < 0 ? -v : v) + (longint'(1) <<< FRAC)) >>> (FRAC + 1);
    return v < 0 ? -m : m;
  endfunction

  // Map an output pixel back onto the source under the current registers
  function automatic sample_t locate_source(logic [9:0] x, logic [9:0] y);
    longint w, h, c, s, ac, as_, ow, oh, xl, yl, dx2, dy2, ix, iy;
    sample_t res;
    w = (src_w_reg > MAX_W) ? MAX_W : src_w_reg;
    h = (src_h_reg > MAX_H) ? MAX_H : src_h_reg;
    c = cos_reg;
    s = sin_reg;
    xl = x;
    yl = y;
    ac = (c < 0) ? -c : c;
    as_ = (s < 0) ? -s : s;
    ow = (w * ac + h * as_) >>> FRAC;
    oh = (w * as_ + h * ac) >>> FRAC;
    if (ow > SIZE_SAT) ow = SIZE_SAT;
    if (oh > SIZE_SAT) oh = SIZE_SAT;
    res = '0;
    res.ow = ow[10:0];
    res.oh = oh[10:0];
    if (xl < ow && yl < oh) begin
      dx2 = 2 * xl - ow;
      dy2 = 2 * yl - oh;
      ix = nearest_index(c * dx2 + s * dy2 + (w <<< FRAC));
      iy = nearest_index(-s * dx2 + c * dy2 + (h <<< FRAC));
      if (ix >= 0 && ix < w && iy >= 0 && iy < h) begin
        res.hit = 1'b1;
        res.addr = 18'(iy * MAX_W + ix);
      end
    end
    return res;
  endfunction

  task automatic queue_cmd(cmd_t op, logic [9:0] x, logic [9:0] y, logic [23:0] rgb,
                           bit hold);
    pixel_cmd_t c;
    c.op = op;
    c.x = x;
    c.y = y;
    {c.r, c.g, c.b} = rgb;
    c.gap = 5'(draw_idle());
    c.hold = hold || ($urandom_range(0, 59) == 0);
    if (op == CMD_READ) begin
      item_total++;
    end else if (x < MAX_W && y < MAX_H) begin
      pix_written[y * MAX_W + x] = 1'b1;
      item_total++;
    end
    pending_cmds.push_back(c);
  endtask

  // Define the sampled source entry first if nothing has written it yet
  task automatic queue_read(logic [9:0] x, logic [9:0] y, bit hold);
    sample_t s;
    s = locate_source(x, y);
    if (s.hit && !pix_written[s.addr])
      queue_cmd(CMD_WRITE, 10'(s.addr % MAX_W), 10'(s.addr / MAX_W), 24'($urandom), 1'b0);
    queue_cmd(CMD_READ, x, y, 24'($urandom), hold);
  endtask

  // Wait until every command is taken and every result is back
  task automatic settle();
    while (pending_cmds.size() > 0 || cmd_valid || expected_pix.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SRC_WIDTH:  src_w_reg = data[9:0];
      CFG_SRC_HEIGHT: src_h_reg = data[9:0];
      CFG_COS_VALUE:  cos_reg = data;
      CFG_SIN_VALUE:  sin_reg = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Reprogram the geometry, then queue a mix of reads, writes and noise
  task automatic run_phase(int w, int h, int c, int s, int n);
    int wq, hq, xmax, ymax, pick;
    sample_t size;
    settle();
    write_register(CFG_SRC_WIDTH, w[15:0]);
    write_register(CFG_SRC_HEIGHT, h[15:0]);
    write_register(CFG_COS_VALUE, c[15:0]);
    write_register(CFG_SIN_VALUE, s[15:0]);
    no_idle = ($urandom_range(0, 3) == 0);
    wq = (w > MAX_W) ? MAX_W : w;
    hq = (h > MAX_H) ? MAX_H : h;
    // Small images get a full fill so reads sample earlier writes
    if (wq * hq <= 160) begin
      for (int yy = 0; yy < hq; yy++)
        for (int xx = 0; xx < wq; xx++)
          queue_cmd(CMD_WRITE, 10'(xx), 10'(yy), 24'($urandom), 1'b0);
    end
    size = locate_source(0, 0);
    xmax = (size.ow == 0) ? 1023 : ((size.ow > 1024) ? 1023 : size.ow - 1);
    ymax = (size.oh == 0) ? 1023 : ((size.oh > 1024) ? 1023 : size.oh - 1);
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        queue_read(10'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, xmax)),
                   10'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, ymax)), 1'b0);
      end else if (pick < 9 && wq > 0 && hq > 0) begin
        queue_cmd(CMD_WRITE, 10'($urandom_range(0, wq - 1)), 10'($urandom_range(0, hq - 1)),
                  24'($urandom), 1'b0);
      end else if ($urandom_range(0, 1) == 0) begin
        queue_cmd(CMD_WRITE, 10'($urandom_range(MAX_W, 1023)), 10'($urandom_range(0, 1023)),
                  24'($urandom), 1'b0);
      end else begin
        queue_cmd(CMD_WRITE, 10'($urandom_range(0, 1023)), 10'($urandom_range(MAX_H, 1023)),
                  24'($urandom), 1'b0);
      end
    end
  endtask

  // Command driver: present queued commands, apply each transfer to the model
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      idle_count = 0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (cmd_valid) begin
        if (cur_cmd.op == CMD_WRITE) begin
          if (cur_cmd.x < MAX_W && cur_cmd.y < MAX_H)
            frame_model[cur_cmd.y * MAX_W + cur_cmd.x] = {cur_cmd.r, cur_cmd.g, cur_cmd.b};
        end else begin
          fetch = locate_source(cur_cmd.x, cur_cmd.y);
          want.blue = COLOR_WHITE;
          want.green = COLOR_WHITE;
          want.red = COLOR_WHITE;
          want.in_src = 1'b0;
          want.width = fetch.ow;
          want.height = fetch.oh;
          if (fetch.hit) begin
            {want.red, want.green, want.blue} = frame_model[fetch.addr];
            want.in_src = 1'b1;
          end
          expected_pix.push_back(want);
        end
      end
      if (pending_cmds.size() > 0 && idle_count >= pending_cmds[0].gap &&
          !(pending_cmds[0].hold && expected_pix.size() > 0)) begin
        cur_cmd = pending_cmds.pop_front();
        command   <= cur_cmd.op;
        coord_x   <= cur_cmd.x;
        coord_y   <= cur_cmd.y;
        in_blue   <= cur_cmd.b;
        in_green  <= cur_cmd.g;
        in_red    <= cur_cmd.r;
        cmd_valid <= 1'b1;
        idle_count = 0;
      end else begin
        cmd_valid <= 1'b0;
        if (pending_cmds.size() > 0) idle_count++;
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_pix.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: rgb %02x%02x%02x in %0b",
                                    out_red, out_green, out_blue, inside_res));
        end else begin
          want = expected_pix.pop_front();
          if (out_blue !== want.blue)
            report_mismatch($sformatf("out_blue %0d, expected %0d", out_blue, want.blue));
          if (out_green !== want.green)
            report_mismatch($sformatf("out_green %0d, expected %0d", out_green, want.green));
          if (out_red !== want.red)
            report_mismatch($sformatf("out_red %0d, expected %0d", out_red, want.red));
          if (inside_res !== want.in_src)
            report_mismatch($sformatf("inside_res %0b, expected %0b", inside_res,
                                      want.in_src));
          if (out_width !== want.width)
            report_mismatch($sformatf("out_width %0d, expected %0d", out_width, want.width));
          if (out_height !== want.height)
            report_mismatch($sformatf("out_height %0d, expected %0d", out_height,
                                      want.height));
        end
        stall_left = draw_idle();
      end
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Stimulus: directed checks at reset geometry, fixed corner phases, then random
  initial begin
    int directed_total, w, h, c, s;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Identity mapping on the full 512 x 512 store
    queue_cmd(CMD_WRITE, 0, 0, 24'h000000, 1'b0);
    queue_cmd(CMD_WRITE, 511, 511, 24'hffffff, 1'b0);
    queue_cmd(CMD_WRITE, 511, 0, 24'h5aa50f, 1'b0);
    queue_cmd(CMD_WRITE, 0, 511, 24'ha55af0, 1'b0);
    queue_cmd(CMD_WRITE, 5, 7, 24'h123456, 1'b0);
    queue_cmd(CMD_WRITE, 5, 7, 24'hedcba9, 1'b0);
    queue_cmd(CMD_WRITE, 0, 4, 24'haa55cc, 1'b0);
    // Writes outside the store must be dropped, not aliased
    queue_cmd(CMD_WRITE, 512, 3, 24'hffffff, 1'b0);
    queue_cmd(CMD_WRITE, 3, 512, 24'hffffff, 1'b0);
    queue_cmd(CMD_WRITE, 1023, 1023, 24'h000000, 1'b0);
    queue_read(0, 0, 1'b0);
    queue_read(511, 511, 1'b0);
    queue_read(511, 0, 1'b0);
    queue_read(0, 511, 1'b0);
    queue_read(5, 7, 1'b1);
    queue_read(0, 4, 1'b0);
    queue_read(3, 2, 1'b0);
    // Reads beyond the output size return background
    queue_read(512, 0, 1'b0);
    queue_read(0, 512, 1'b0);
    queue_read(1023, 1023, 1'b0);
    directed_total = item_total;

    // Fixed phases: rotations, zero and oversized sizes, extreme trig values
    run_phase(8, 6, 16384, 0, 40);
    run_phase(16, 10, 0, 16384, 40);
    run_phase(12, 12, 11585, 11585, 40);
    run_phase(512, 512, 14189, 8192, 50);
    run_phase(0, 20, 16384, 0, 20);
    run_phase(20, 0, 11585, -11585, 20);
    run_phase(1023, 700, -16384, 0, 40);
    run_phase(512, 512, -32768, -32768, 40);
    run_phase(300, 200, 32767, -32768, 30);
    run_phase(1, 1, 16384, 0, 20);
    run_phase(1, 1, -11585, 11585, 20);
    run_phase(9, 5, 16384, 16384, 30);

    // Random geometry, mostly small images
    while (item_total < directed_total + RANDOM_ITEMS) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 24);
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 24);
      if ($urandom_range(0, 5) == 0) begin
        c = $urandom_range(0, 65535);
        s = $urandom_range(0, 65535);
        c = c - 32768;
        s = s - 32768;
      end else begin
        c = $urandom_range(0, 32768);
        s = $urandom_range(0, 32768);
        c = c - 16384;
        s = s - 16384;
      end
      run_phase(w, h, c, s, $urandom_range(30, 70));
    end

    settle();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
